// ===== rtl/mlpd_pkg.sv =====
// Shared types and constants for the magic-framed, length-prefixed deframer.
// It has no dependencies. The front, queue, back and top-level files import it.
package mlpd_pkg;

  localparam int MAX_BODY_DEF = 256;
  localparam int Q_DEPTH_DEF  = 2;

  localparam int HDR_BYTES = 12;
  // Only the first ten header bytes carry information; the reserved pair is skipped.
  localparam int HDR_KEEP  = 10;
  localparam int HDR_W     = HDR_KEEP * 8;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam logic [31:0] MAGIC_RST  = 32'hCAFE_BABE;
  localparam logic [15:0] TYPE_RST   = 16'd300;
  localparam logic [8:0]  MAXLEN_RST = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC  = 2'd0,
    CFG_TYPE   = 2'd1,
    CFG_MAXLEN = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  body_byte;
    logic        last;
    logic [8:0]  msg_len;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/mlpd_front.sv =====
// Front end of the deframer: it holds the configuration registers, gathers headers,
// classifies them and tracks the body count. It depends on mlpd_pkg.
module mlpd_front
  import mlpd_pkg::*;
#(
  parameter int MAX_BODY = MAX_BODY_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           stream_byte_i,
  input  logic                 close_stream_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output logic                 push_o,
  output result_t              push_data_o
);

  localparam int LenW = $clog2(MAX_BODY + 1);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_BODY = 2'd1,
    PH_DROP = 2'd2
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [3:0]      fill_q, fill_d;
  logic [LenW-1:0] left_q, left_d;
  logic [8:0]      total_q, total_d;
  logic [HDR_W-1:0] hdr_q, hdr_d;
  logic [31:0]     magic_q;
  logic [15:0]     type_q;
  logic [8:0]      maxlen_q;

  logic [31:0] hdr_magic, hdr_len, limit;
  logic [15:0] hdr_type;
  logic        hdr_bad;

  // The header is taken apart from the shift register after the ten meaningful bytes.
  assign hdr_magic = hdr_q[HDR_W-1 -: 32];
  assign hdr_len   = hdr_q[HDR_W-33 -: 32];
  assign hdr_type  = hdr_q[15:0];
  assign limit     = (32'(maxlen_q) > 32'(MAX_BODY)) ? 32'(MAX_BODY) : 32'(maxlen_q);
  assign hdr_bad   = (hdr_magic != magic_q) || (hdr_type != type_q) || (hdr_len > limit);

  always_comb begin
    phase_d     = phase_q;
    fill_d      = fill_q;
    left_d      = left_q;
    total_d     = total_q;
    hdr_d       = hdr_q;
    push_o      = 1'b0;
    push_data_o = '{kind: KIND_BYTE, body_byte: 8'd0, last: 1'b0, msg_len: 9'd0};
    if (accept_i) begin
      if (close_stream_i) begin
        phase_d = PH_HUNT;
        fill_d  = 4'd0;
        left_d  = '0;
        total_d = 9'd0;
      end else begin
        unique case (phase_q)
          PH_BODY: begin
            push_o                = 1'b1;
            push_data_o.body_byte = stream_byte_i;
            push_data_o.last      = (left_q <= LenW'(1));
            push_data_o.msg_len   = total_q;
            if (left_q != '0) begin
              left_d = left_q - LenW'(1);
            end
            if (left_q <= LenW'(1)) begin
              phase_d = PH_HUNT;
            end
          end
          PH_HUNT: begin
            if (fill_q < 4'(HDR_KEEP)) begin
              hdr_d = {hdr_q[HDR_W-9:0], stream_byte_i};
            end
            if (fill_q == 4'(HDR_BYTES - 1)) begin
              fill_d = 4'd0;
              if (hdr_bad) begin
                phase_d          = PH_DROP;
                left_d           = '0;
                total_d          = 9'd0;
                push_o           = 1'b1;
                push_data_o.kind = KIND_ERROR;
              end else if (hdr_len == 32'd0) begin
                left_d           = '0;
                total_d          = 9'd0;
                push_o           = 1'b1;
                push_data_o.kind = KIND_EMPTY;
                push_data_o.last = 1'b1;
              end else begin
                left_d  = LenW'(hdr_len);
                total_d = hdr_len[8:0];
                phase_d = PH_BODY;
              end
            end else begin
              fill_d = fill_q + 4'd1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      fill_q   <= 4'd0;
      left_q   <= '0;
      total_q  <= 9'd0;
      magic_q  <= MAGIC_RST;
      type_q   <= TYPE_RST;
      maxlen_q <= MAXLEN_RST;
    end else begin
      phase_q <= phase_d;
      fill_q  <= fill_d;
      left_q  <= left_d;
      total_q <= total_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_MAGIC:  magic_q  <= cfg_data_i;
          CFG_TYPE:   type_q   <= cfg_data_i[15:0];
          CFG_MAXLEN: maxlen_q <= cfg_data_i[8:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
  end

endmodule

// ===== rtl/mlpd_queue.sv =====
// Short result queue between the front and back ends of the deframer.
// It depends on mlpd_pkg for the result type.
module mlpd_queue
  import mlpd_pkg::*;
#(
  parameter int QDEPTH = Q_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  result_t                     push_data_i,
  input  logic                        pop_i,
  output result_t                     pop_data_o,
  output q_status_t                   status_o,
  output logic [$clog2(QDEPTH+1)-1:0] level_o
);

  localparam int PtrW = $clog2(QDEPTH);
  localparam int CntW = $clog2(QDEPTH + 1);

  result_t         mem_q [QDEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign pop_data_o     = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == CntW'(QDEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign level_o        = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/mlpd_back.sv =====
// Back end of the deframer: the output register that presents result beats.
// It depends on mlpd_pkg for the result type and the queue status.
module mlpd_back
  import mlpd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_status_t q_status_i,
  input  result_t   q_data_i,
  output logic      pop_o,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output result_t   out_data_o
);

  logic    valid_q;
  result_t data_q;

  // Refill whenever the register is empty or its beat is taken this cycle.
  assign pop_o       = !q_status_i.empty && (!valid_q || !out_stall_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || !out_stall_i) begin
      valid_q <= !q_status_i.empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= q_data_i;
    end
  end

endmodule

// ===== rtl/magic_length_prefixed_deframer_top.sv =====
// Top level of the magic-framed, length-prefixed stream deframer.
// It instantiates mlpd_front, mlpd_queue and mlpd_back and depends on mlpd_pkg.
//
// Usage: stream bytes enter on the input channel, one byte per beat. A beat is taken
// at a rising edge where in_valid_i is high and in_stall_o is low. A beat with
// close_stream_i set ends the connection: its byte is ignored, any partial header
// or body is dropped, and the block hunts for a new 12-byte header. Results leave
// on the output channel. A result beat is taken where out_valid_o is high and
// out_stall_i is low. A result beat is a body byte, an empty-message marker, or a
// framing error. After a framing error, bytes are dropped until a close beat.
// Configuration writes use cfg_valid_i/cfg_ready_o, with index 0 for magic, 1 for
// type and 2 for the body length limit. Writes to other indexes are ignored.
// Configuration is to be written by the user only while the block is idle; the block
// does not enforce this. Throughput is one byte per cycle while in_stall_o is low. The
// front end does one compare set and one counter update per beat. A result is
// registered into the result queue and then into the output register before it is
// visible. When the receiver stalls, results collect in the queue. Once the queue is
// full, in_stall_o rises. At reset, the control and configuration registers take their
// default values and the parser starts hunting for a header. There is no clearing pass.
module magic_length_prefixed_deframer_top
  import mlpd_pkg::*;
#(
  parameter int MAX_BODY = MAX_BODY_DEF,
  parameter int QDEPTH   = Q_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           stream_byte_i,
  input  logic                 close_stream_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           result_kind_o,
  output logic [7:0]           body_byte_o,
  output logic                 last_of_message_o,
  output logic [8:0]           message_length_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  logic                        accept;
  logic                        push, pop;
  result_t                     push_data, q_data, out_data;
  q_status_t                   q_status;
  logic [$clog2(QDEPTH+1)-1:0] q_level;

  // The stall comes from the registered queue fill only, so it never waits on the input valid.
  assign in_stall_o  = q_status.full;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  mlpd_front #(
    .MAX_BODY(MAX_BODY)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .stream_byte_i  (stream_byte_i),
    .close_stream_i (close_stream_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  mlpd_queue #(
    .QDEPTH(QDEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (q_data),
    .status_o    (q_status),
    .level_o     (q_level)
  );

  mlpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data)
  );

  assign result_kind_o     = out_data.kind;
  assign body_byte_o       = out_data.body_byte;
  assign last_of_message_o = out_data.last;
  assign message_length_o  = out_data.msg_len;

  // The queue never holds more entries than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(q_level) <= QDEPTH)
    else $error("result queue overfilled");

  // An error beat carries no length and no last flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == KIND_ERROR) |->
      (message_length_o == 9'd0 && !last_of_message_o && body_byte_o == 8'd0))
    else $error("framing error beat carries payload");

  // An empty-message beat always closes its message.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == KIND_EMPTY) |->
      (last_of_message_o && message_length_o == 9'd0))
    else $error("empty message beat malformed");

  // A queue entry is read only when there is one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("pop from empty result queue");

endmodule

// ===== verif/magic_length_prefixed_deframer_top_tb.sv =====
// Self-checking testbench for magic_length_prefixed_deframer_top.
// It depends on mlpd_pkg and on the deframer RTL, and nothing else.
// It drives framed byte streams through the block and scores every result.
module magic_length_prefixed_deframer_top_tb;
  import mlpd_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int BODY_CAP   = MAX_BODY_DEF;
  // Register index 3 is not decoded; writes to it must leave the setup unchanged.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // Parser phase of the scoreboard's own copy of the deframer.
  typedef enum logic [1:0] {
    HUNTING,
    IN_BODY,
    DISCARDING
  } parse_state_e;

  // One row of the directed table is one whole frame: a 12-byte header, a run
  // of trailing bytes (body or dropped) and an optional close beat. Each row
  // yields exactly one result, and where it is obvious it is typed in here.
  typedef struct {
    logic [31:0] magic;
    logic [31:0] length;
    logic [15:0] mtype;
    logic [15:0] rsvd;
    int          trail;
    logic [7:0]  fill;
    bit          close_after;
    bit          typed;
    result_t     want;
  } frame_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [7:0]           stream_byte_i;
  logic                 close_stream_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [1:0]           result_kind_o;
  logic [7:0]           body_byte_o;
  logic                 last_of_message_o;
  logic [8:0]           message_length_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;

  // Scoreboard copy of the configuration registers.
  logic [31:0] cfg_magic;
  logic [15:0] cfg_type;
  logic [8:0]  cfg_maxlen;

  // Scoreboard copy of the parser state.
  logic [7:0]   hdr_bytes [HDR_BYTES];
  int unsigned  hdr_count;
  int unsigned  bytes_left;
  logic [8:0]   msg_total;
  parse_state_e parse_st;

  result_t pending_results [$];

  // While set, every predicted result is replaced by a value from the table.
  bit      typed_on;
  result_t typed_val;

  // Both sides stop idling while this is set.
  bit calm;

  int unsigned beats_sent;
  int unsigned beats_counted;
  int unsigned mismatches;
  int unsigned seen_bytes;
  int unsigned seen_empty;
  int unsigned seen_errors;

  frame_row_t directed_frames [3] = '{
    // Good header with a zero length: one empty-message beat. The reserved
    // half-word is all ones to show that it is ignored.
    '{MAGIC_RST, 32'd0, TYPE_RST, 16'hFFFF, 0, 8'h00, 1'b0, 1'b1,
      '{KIND_EMPTY, 8'h00, 1'b1, 9'd0}},
    // Good header with a one-byte body: the only body byte is also the last.
    '{MAGIC_RST, 32'd1, TYPE_RST, 16'h0000, 1, 8'hFF, 1'b0, 1'b1,
      '{KIND_BYTE, 8'hFF, 1'b1, 9'd1}},
    // All-zero magic: framing error, then a dropped byte and a close beat.
    '{32'h0000_0000, 32'd0, TYPE_RST, 16'h0000, 1, 8'h00, 1'b1, 1'b1,
      '{KIND_ERROR, 8'h00, 1'b0, 9'd0}}
  };

  magic_length_prefixed_deframer_top #(
    .MAX_BODY(BODY_CAP)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .stream_byte_i    (stream_byte_i),
    .close_stream_i   (close_stream_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_kind_o    (result_kind_o),
    .body_byte_o      (body_byte_o),
    .last_of_message_o(last_of_message_o),
    .message_length_o (message_length_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Advances the scoreboard parser by one accepted input beat. Returns 1 and
  // fills r when the beat produces a result.
  function automatic bit deframe_step(input logic [7:0] b, input logic c, output result_t r);
    logic [31:0] magic;
    logic [31:0] length;
    logic [15:0] mtype;
    int unsigned limit;
    r = '0;
    // A close beat wins in every phase and throws away any partial frame.
    if (c) begin
      hdr_count  = 0;
      bytes_left = 0;
      msg_total  = '0;
      parse_st   = HUNTING;
      return 1'b0;
    end
    case (parse_st)
      IN_BODY: begin
        r.kind      = KIND_BYTE;
        r.body_byte = b;
        r.last      = (bytes_left <= 1);
        r.msg_len   = msg_total;
        if (bytes_left > 0) bytes_left--;
        if (bytes_left == 0) parse_st = HUNTING;
        return 1'b1;
      end
      DISCARDING: begin
        return 1'b0;
      end
      default: begin
        hdr_bytes[hdr_count] = b;
        hdr_count++;
        if (hdr_count < HDR_BYTES) return 1'b0;
        hdr_count = 0;
        magic  = {hdr_bytes[0], hdr_bytes[1], hdr_bytes[2], hdr_bytes[3]};
        length = {hdr_bytes[4], hdr_bytes[5], hdr_bytes[6], hdr_bytes[7]};
        mtype  = {hdr_bytes[8], hdr_bytes[9]};
        // A limit register above the build-time cap acts as the cap.
        limit = (cfg_maxlen > BODY_CAP) ? BODY_CAP : cfg_maxlen;
        if (magic != cfg_magic || mtype != cfg_type || length > limit) begin
          parse_st   = DISCARDING;
          bytes_left = 0;
          msg_total  = '0;
          r.kind     = KIND_ERROR;
          return 1'b1;
        end
        if (length == 0) begin
          bytes_left = 0;
          msg_total  = '0;
          r.kind     = KIND_EMPTY;
          r.last     = 1'b1;
          return 1'b1;
        end
        bytes_left = length;
        msg_total  = length[8:0];
        parse_st   = IN_BODY;
        return 1'b0;
      end
    endcase
  endfunction

  // Offers one stream beat, after a random idle gap, and scores it once taken.
  // Valid is only lowered when a gap really follows, so it never drops and
  // rises again within one time step.
  task automatic send_beat(input logic [7:0] b, input logic c);
    int unsigned gap;
    result_t     r;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(99) < 37) gap++;
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    stream_byte_i  <= b;
    close_stream_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    // Bytes that are merely dropped after a framing error are not counted.
    if (c || parse_st != DISCARDING) beats_counted++;
    beats_sent++;
    if (deframe_step(b, c, r)) begin
      pending_results.push_back(typed_on ? typed_val : r);
    end
  endtask

  // Sends the first nbytes of a big-endian header.
  task automatic send_header(input logic [31:0] magic, input logic [31:0] length,
                             input logic [15:0] mtype, input logic [15:0] rsvd,
                             input int nbytes);
    logic [95:0] hdr;
    hdr = {magic, length, mtype, rsvd};
    for (int i = 0; i < nbytes; i++) begin
      send_beat(hdr[95 - 8 * i -: 8], 1'b0);
    end
  endtask

  // Stops offering beats until every expected result has come back, then lets
  // the pipeline finish any header beat that produced no result.
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MAGIC:  cfg_magic  = data;
      CFG_TYPE:   cfg_type   = data[15:0];
      CFG_MAXLEN: cfg_maxlen = data[8:0];
      default: ;
    endcase
  endtask

  // Writes all three registers, and the spare index when asked, while the block is
  // idle. Unused upper data bits are random, since the block must ignore them.
  task automatic apply_setting(input logic [31:0] magic, input logic [15:0] mtype,
                               input logic [8:0] maxlen, input bit spare);
    logic [15:0] type_pad;
    logic [22:0] len_pad;
    type_pad = 16'($urandom);
    len_pad  = 23'($urandom);
    settle_idle();
    write_reg(CFG_MAGIC, magic);
    write_reg(CFG_TYPE, {type_pad, mtype});
    write_reg(CFG_MAXLEN, {len_pad, maxlen});
    if (spare) write_reg(CFG_SPARE, $urandom);
    cfg_valid_i <= 1'b0;
  endtask

  // One random frame. Most are well formed so that bodies get exercised; the
  // rest are bad headers, headers cut short by a close, and loose noise.
  task automatic send_random_frame();
    int          pick;
    int          limit;
    int          len;
    int          cut;
    int          n;
    logic [31:0] magic;
    logic [31:0] length;
    logic [15:0] mtype;
    limit = (cfg_maxlen > BODY_CAP) ? BODY_CAP : cfg_maxlen;
    magic = cfg_magic;
    mtype = cfg_type;
    // Short bodies keep the run quick; now and then a body of the full limit.
    if ($urandom_range(29) == 0) len = limit;
    else if ($urandom_range(7) == 0) len = 0;
    else len = $urandom_range(0, (limit < 24) ? limit : 24);
    length = len;
    pick = $urandom_range(99);
    if (pick < 62) begin
      send_header(magic, length, mtype, 16'($urandom), HDR_BYTES);
      // Sometimes the connection closes in the middle of the body.
      cut = (len > 0 && $urandom_range(7) == 0) ? $urandom_range(0, len - 1) : len;
      for (int i = 0; i < cut; i++) send_beat(8'($urandom), 1'b0);
      if (cut < len || $urandom_range(5) == 0) send_beat(8'($urandom), 1'b1);
    end else if (pick < 88) begin
      if (pick < 70) magic = magic ^ (32'd1 << $urandom_range(31));
      else if (pick < 78) mtype = mtype ^ (16'd1 << $urandom_range(15));
      else if ($urandom_range(1) == 0) length = limit + 1;
      else length = $urandom | 32'h0000_0200;
      send_header(magic, length, mtype, 16'($urandom), HDR_BYTES);
      // Everything after a framing error is dropped until the close beat.
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) send_beat(8'($urandom), 1'b0);
      send_beat(8'($urandom), 1'b1);
    end else if (pick < 94) begin
      send_header(magic, length, mtype, 16'($urandom), $urandom_range(1, HDR_BYTES - 1));
      send_beat(8'($urandom), 1'b1);
    end else begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) send_beat(8'($urandom), 1'b0);
      send_beat(8'($urandom), 1'b1);
    end
  endtask

  // Receiver: stalls at random, except during the calm phase. Once, after a
  // good number of results, it holds off for a long stretch while the sender
  // keeps offering beats, so the result queue fills and the input stalls.
  initial begin
    int unsigned taken;
    int unsigned hold;
    bit          held;
    taken = 0;
    hold  = 0;
    held  = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) taken++;
      if (!held && taken >= 150 && in_valid_i) begin
        held = 1'b1;
        hold = 120;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 37);
      end
    end
  end

  // Result checker: every accepted result beat is compared with the oldest
  // expectation, field by field.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected: kind %0d byte %02h last %0b len %0d",
                 $time, result_kind_o, body_byte_o, last_of_message_o, message_length_o);
      end else begin
        want = pending_results.pop_front();
        case (want.kind)
          KIND_BYTE:  seen_bytes++;
          KIND_EMPTY: seen_empty++;
          default:    seen_errors++;
        endcase
        if (result_kind_o !== want.kind) begin
          mismatches++;
          $display("%0t: result_kind expected %0d, got %0d", $time, want.kind, result_kind_o);
        end
        if (body_byte_o !== want.body_byte) begin
          mismatches++;
          $display("%0t: body_byte expected %02h, got %02h", $time, want.body_byte,
                   body_byte_o);
        end
        if (last_of_message_o !== want.last) begin
          mismatches++;
          $display("%0t: last_of_message expected %0b, got %0b", $time, want.last,
                   last_of_message_o);
        end
        if (message_length_o !== want.msg_len) begin
          mismatches++;
          $display("%0t: message_length expected %0d, got %0d", $time, want.msg_len,
                   message_length_o);
        end
      end
    end
  end

  // Main stimulus: reset, the directed frames at the reset setup, then five
  // random phases, each under its own register setting.
  initial begin
    int unsigned target;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    stream_byte_i  <= 8'h00;
    close_stream_i <= 1'b0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= CFG_MAGIC;
    cfg_data_i     <= '0;
    cfg_magic      = MAGIC_RST;
    cfg_type       = TYPE_RST;
    cfg_maxlen     = MAXLEN_RST;
    hdr_count      = 0;
    bytes_left     = 0;
    msg_total      = '0;
    parse_st       = HUNTING;
    typed_on       = 1'b0;
    typed_val      = '0;
    calm           = 1'b0;
    beats_sent     = 0;
    beats_counted  = 0;
    mismatches     = 0;
    seen_bytes     = 0;
    seen_empty     = 0;
    seen_errors    = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames, checked against the values typed into the table.
    foreach (directed_frames[k]) begin
      typed_on  = directed_frames[k].typed;
      typed_val = directed_frames[k].want;
      send_header(directed_frames[k].magic, directed_frames[k].length,
                  directed_frames[k].mtype, directed_frames[k].rsvd, HDR_BYTES);
      for (int i = 0; i < directed_frames[k].trail; i++) begin
        send_beat(8'(directed_frames[k].fill + i), 1'b0);
      end
      if (directed_frames[k].close_after) send_beat(~directed_frames[k].fill, 1'b1);
    end
    typed_on = 1'b0;

    // Random phases. The first takes the low extremes, where a zero limit lets
    // only empty messages through; the second the high extremes without any
    // idling; the third a limit above the cap plus a write to the spare index.
    for (int ph = 1; ph <= 5; ph++) begin
      case (ph)
        1: apply_setting(32'hFFFF_FFFF, 16'h0000, 9'd0, 1'b0);
        2: apply_setting(32'h0000_0000, 16'hFFFF, 9'd256, 1'b0);
        3: apply_setting($urandom, 16'($urandom), 9'h1FF, 1'b1);
        4: apply_setting($urandom, 16'($urandom), 9'($urandom_range(1, 40)), 1'b0);
        default: apply_setting(MAGIC_RST, TYPE_RST, 9'd1, 1'b0);
      endcase
      calm   = (ph == 2);
      target = beats_counted + 90;
      while (beats_counted < target) send_random_frame();
    end
    calm = 1'b0;

    settle_idle();
    $display("Sent %0d stream beats over six register setups; checked %0d results:",
             beats_sent, seen_bytes + seen_empty + seen_errors);
    $display("%0d body bytes, %0d empty messages, %0d framing errors, %0d mismatches.",
             seen_bytes, seen_empty, seen_errors, mismatches);
    if (mismatches == 0) begin
      $display("magic_length_prefixed_deframer_top verification clean");
    end else begin
      $display("magic_length_prefixed_deframer_top verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(CLK_PERIOD * 500_000);
    $display("Timeout with %0d results still expected.", pending_results.size());
    $display("magic_length_prefixed_deframer_top verification failed");
    $finish;
  end

endmodule
